FILE: hw/rtl/ofe_pkg.sv
// Shared types and constants for the order feed enricher.
`default_nettype none
package ofe_pkg;

    localparam int ORDERS_PER_SIDE = 1024;
    localparam int TABLE_WAYS      = 4;
    localparam int SIDE_COUNT      = 2;
    localparam logic [7:0] SIDE_BASE = 8'h30;
    localparam int HASH_W          = 32;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_DEL   = 3'd1,
        KIND_EXEC  = 3'd2,
        KIND_CLEAR = 3'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SIDE  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNKNOWN   = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_RD,
        S_CMP,
        S_EXEC
    } t_state;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_SCALE,
        P_SUB
    } t_idx_phase;

    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] key;
    } t_hash_req;

endpackage
`default_nettype wire

FILE: hw/rtl/ofe_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module ofe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ofe_setidx.sv
// Set index unit: hashed key modulo set count by reciprocal multiplication, in multiply, scale and subtract steps.
`default_nettype none
module ofe_setidx #(
    parameter int SET_COUNT = 256
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire ofe_pkg::t_hash_req                            i_req,
    output logic                                               o_done,
    output logic [(SET_COUNT > 1 ? $clog2(SET_COUNT) : 1)-1:0] o_set
);
    localparam int SET_AW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int SH     = $clog2(SET_COUNT);
    localparam int HW     = ofe_pkg::HASH_W;
    localparam int PW     = 2 * HW + 1;
    localparam logic [HW:0] RECIP =
        (HW + 1)'(((64'd1 << (HW + SH)) + 64'(SET_COUNT) - 64'd1) / 64'(SET_COUNT));

    ofe_pkg::t_idx_phase r_ph, n_ph;

    logic              r_done, n_done;
    logic [HW-1:0]     r_val, n_val;
    logic [PW-1:0]     r_prod, n_prod;
    logic [HW-1:0]     r_qs, n_qs;
    logic [SET_AW-1:0] r_rem, n_rem;

    always_comb begin
        n_ph = r_ph;
        unique case (r_ph)
            ofe_pkg::P_IDLE:  if (i_req.start) n_ph = ofe_pkg::P_MUL;
            ofe_pkg::P_MUL:   n_ph = ofe_pkg::P_SCALE;
            ofe_pkg::P_SCALE: n_ph = ofe_pkg::P_SUB;
            ofe_pkg::P_SUB:   n_ph = ofe_pkg::P_IDLE;
            default:          n_ph = ofe_pkg::P_IDLE;
        endcase
    end

    always_comb begin
        n_done = 1'b0;
        n_val  = r_val;
        n_prod = r_prod;
        n_qs   = r_qs;
        n_rem  = r_rem;
        unique case (r_ph)
            ofe_pkg::P_IDLE: begin
                if (i_req.start) n_val = i_req.key;
            end
            ofe_pkg::P_MUL: begin
                n_prod = PW'(r_val) * PW'(RECIP);
            end
            ofe_pkg::P_SCALE: begin
                n_qs = HW'(r_prod >> (HW + SH)) * HW'(SET_COUNT);
            end
            ofe_pkg::P_SUB: begin
                n_rem  = SET_AW'(r_val - r_qs);
                n_done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= ofe_pkg::P_IDLE;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= n_done;
        end
        r_val  <= n_val;
        r_prod <= n_prod;
        r_qs   <= n_qs;
        r_rem  <= n_rem;
    end

    assign o_done = r_done;
    assign o_set  = r_rem;
endmodule
`default_nettype wire

FILE: hw/rtl/order_feed_enricher_core.sv
// Top level of the order feed enricher: event sequencer over the order table.
//
// One event beat is taken at a clock edge with start high and busy low. Each
// event gives exactly one result beat on the o_out_* ports, marked by o_strobe
// for one cycle; the receiver cannot stall, so results are never held back.
// Events with a bad side, unknown kinds and delete-all give their result in
// the cycle after acceptance. Add, delete and execute go through the table:
// the set index comes from the reciprocal-multiply modulo unit, then each way
// takes a read step and a compare step on the shared entry RAM read port,
// the search stopping at a hit, and a write-back step follows.
// Busy stays high until the cycle of the result beat.
// A delete-all clears the valid RAM one set row a cycle, all SIDE_COUNT *
// ORDERS_PER_SIDE / TABLE_WAYS rows (512 by default), with busy high.
// After reset the same clearing pass runs before the first event is taken.
`default_nettype none
module order_feed_enricher_core #(
    parameter int ORDERS_PER_SIDE = ofe_pkg::ORDERS_PER_SIDE,
    parameter int TABLE_WAYS      = ofe_pkg::TABLE_WAYS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_seq_num,
    input  wire logic [63:0] i_timestamp,
    input  wire logic [63:0] i_ord_key,
    input  wire logic [7:0]  i_side,
    input  wire logic [31:0] i_quantity,
    input  wire logic [63:0] i_price_bits,
    output logic             o_strobe,
    output logic [2:0]       o_out_kind,
    output logic [31:0]      o_out_seq_num,
    output logic [63:0]      o_out_timestamp,
    output logic [63:0]      o_out_ord_key,
    output logic [7:0]       o_out_side,
    output logic [31:0]      o_out_quantity,
    output logic [63:0]      o_out_price_bits,
    output logic             o_full_exec,
    output logic [2:0]       o_status
);
    localparam int SET_COUNT = ORDERS_PER_SIDE / TABLE_WAYS;
    localparam int SET_AW    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int ROWS      = ofe_pkg::SIDE_COUNT * SET_COUNT;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int ENTRIES   = ROWS * TABLE_WAYS;
    localparam int ENT_AW    = $clog2(ENTRIES);
    localparam int WAY_AW    = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam int SIDE_AW   = $clog2(ofe_pkg::SIDE_COUNT);
    localparam int EW        = 160;

    ofe_pkg::t_state r_state, n_state;

    logic [ROW_AW-1:0]     r_clr, n_clr;
    logic [ROW_AW-1:0]     r_row, n_row;
    logic [WAY_AW-1:0]     r_way, n_way;
    logic [SIDE_AW-1:0]    r_sidx, n_sidx;
    logic                  r_found, n_found;
    logic [WAY_AW-1:0]     r_fway, n_fway;
    logic [31:0]           r_fsize, n_fsize;
    logic [63:0]           r_fprice, n_fprice;
    logic                  r_free, n_free;
    logic [WAY_AW-1:0]     r_free_way, n_free_way;
    logic [TABLE_WAYS-1:0] r_vrow, n_vrow;

    logic [2:0]  r_kind, n_kind;
    logic [63:0] r_id, n_id;
    logic [31:0] r_qty, n_qty;
    logic [63:0] r_price, n_price;

    logic        r_strobe, n_strobe;
    logic [2:0]  r_o_kind, n_o_kind;
    logic [31:0] r_o_seq, n_o_seq;
    logic [63:0] r_o_ts, n_o_ts;
    logic [63:0] r_o_id, n_o_id;
    logic [7:0]  r_o_side, n_o_side;
    logic [31:0] r_o_qty, n_o_qty;
    logic [63:0] r_o_price, n_o_price;
    logic        r_o_full, n_o_full;
    logic [2:0]  r_o_status, n_o_status;

    logic                  v_we;
    logic [ROW_AW-1:0]     v_waddr;
    logic [TABLE_WAYS-1:0] v_wdata, v_rdata;
    logic                  e_we;
    logic [ENT_AW-1:0]     e_waddr, e_raddr;
    logic [WAY_AW-1:0]     e_wway;
    logic [EW-1:0]         e_wdata, e_rdata;

    ofe_pkg::t_hash_req    hreq;
    logic                  h_done;
    logic [SET_AW-1:0]     h_set;
    logic [31:0]           h_fold;

    logic acc, side_ok, kind_tab, go_table, go_clear, cmp_hit, last_way;

    assign busy     = (r_state != ofe_pkg::S_IDLE);
    assign acc      = start && !busy;
    assign side_ok  = ({1'b0, i_side} >= {1'b0, ofe_pkg::SIDE_BASE})
                   && ({1'b0, i_side} < ({1'b0, ofe_pkg::SIDE_BASE} + 9'(ofe_pkg::SIDE_COUNT)));
    assign kind_tab = i_kind inside {ofe_pkg::KIND_ADD, ofe_pkg::KIND_DEL, ofe_pkg::KIND_EXEC};
    assign go_table = acc && kind_tab && side_ok;
    assign go_clear = acc && (i_kind == ofe_pkg::KIND_CLEAR);
    assign cmp_hit  = v_rdata[r_way] && (e_rdata[159:96] == r_id);
    assign last_way = (r_way == WAY_AW'(TABLE_WAYS - 1));

    assign h_fold     = (i_ord_key[31:0] ^ i_ord_key[63:32])
                      ^ ((i_ord_key[31:0] ^ i_ord_key[63:32]) >> 16);
    assign hreq.start = go_table;
    assign hreq.key   = h_fold;

    assign e_raddr = ENT_AW'(r_row) * ENT_AW'(TABLE_WAYS) + ENT_AW'(r_way);
    assign e_waddr = ENT_AW'(r_row) * ENT_AW'(TABLE_WAYS) + ENT_AW'(e_wway);

    ofe_setidx #(.SET_COUNT(SET_COUNT)) u_setidx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hreq),
        .o_done  (h_done),
        .o_set   (h_set)
    );

    ofe_ram #(.WIDTH(TABLE_WAYS), .DEPTH(ROWS)) u_valid_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (r_row),
        .o_rdata (v_rdata)
    );

    ofe_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ofe_pkg::S_CLEAR: if (r_clr == ROW_AW'(ROWS - 1)) n_state = ofe_pkg::S_IDLE;
            ofe_pkg::S_IDLE: begin
                if (go_table) n_state = ofe_pkg::S_HASH;
                else if (go_clear) n_state = ofe_pkg::S_CLEAR;
            end
            ofe_pkg::S_HASH: if (h_done) n_state = ofe_pkg::S_RD;
            ofe_pkg::S_RD:   n_state = ofe_pkg::S_CMP;
            ofe_pkg::S_CMP:  n_state = (cmp_hit || last_way) ? ofe_pkg::S_EXEC : ofe_pkg::S_RD;
            ofe_pkg::S_EXEC: n_state = ofe_pkg::S_IDLE;
            default:         n_state = ofe_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_clr      = r_clr;
        n_row      = r_row;
        n_way      = r_way;
        n_sidx     = r_sidx;
        n_found    = r_found;
        n_fway     = r_fway;
        n_fsize    = r_fsize;
        n_fprice   = r_fprice;
        n_free     = r_free;
        n_free_way = r_free_way;
        n_vrow     = r_vrow;
        n_kind     = r_kind;
        n_id       = r_id;
        n_qty      = r_qty;
        n_price    = r_price;
        n_strobe   = 1'b0;
        n_o_kind   = r_o_kind;
        n_o_seq    = r_o_seq;
        n_o_ts     = r_o_ts;
        n_o_id     = r_o_id;
        n_o_side   = r_o_side;
        n_o_qty    = r_o_qty;
        n_o_price  = r_o_price;
        n_o_full   = r_o_full;
        n_o_status = r_o_status;
        v_we       = 1'b0;
        v_waddr    = r_row;
        v_wdata    = r_vrow;
        e_we       = 1'b0;
        e_wway     = r_fway;
        e_wdata    = {r_id, r_qty, r_price};

        unique case (r_state)
            ofe_pkg::S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr;
                v_wdata = '0;
                n_clr   = r_clr + 1'b1;
            end
            ofe_pkg::S_IDLE: begin
                if (acc) begin
                    n_kind     = i_kind;
                    n_id       = i_ord_key;
                    n_qty      = i_quantity;
                    n_price    = i_price_bits;
                    n_sidx     = SIDE_AW'(i_side - ofe_pkg::SIDE_BASE);
                    n_o_kind   = i_kind;
                    n_o_seq    = i_seq_num;
                    n_o_ts     = i_timestamp;
                    n_o_id     = i_ord_key;
                    n_o_side   = i_side;
                    n_o_qty    = i_quantity;
                    n_o_price  = i_price_bits;
                    n_o_full   = 1'b0;
                    n_o_status = ofe_pkg::ST_OK;
                    n_clr      = '0;
                    unique case (i_kind)
                        ofe_pkg::KIND_ADD, ofe_pkg::KIND_EXEC: begin
                            n_o_status = ofe_pkg::ST_BAD_SIDE;
                            n_strobe   = !side_ok;
                        end
                        ofe_pkg::KIND_DEL: begin
                            n_o_status = ofe_pkg::ST_BAD_SIDE;
                            n_o_qty    = '0;
                            n_o_price  = '0;
                            n_strobe   = !side_ok;
                        end
                        ofe_pkg::KIND_CLEAR: begin
                            n_o_id    = '0;
                            n_o_side  = '0;
                            n_o_qty   = '0;
                            n_o_price = '0;
                            n_strobe  = 1'b1;
                        end
                        default: begin
                            n_o_status = ofe_pkg::ST_UNKNOWN;
                            n_strobe   = 1'b1;
                        end
                    endcase
                end
            end
            ofe_pkg::S_HASH: begin
                if (h_done) begin
                    n_row   = ROW_AW'(ROW_AW'(r_sidx) * ROW_AW'(SET_COUNT) + ROW_AW'(h_set));
                    n_way   = '0;
                    n_found = 1'b0;
                    n_free  = 1'b0;
                end
            end
            ofe_pkg::S_RD: begin
            end
            ofe_pkg::S_CMP: begin
                n_vrow = v_rdata;
                if (cmp_hit) begin
                    n_found  = 1'b1;
                    n_fway   = r_way;
                    n_fsize  = e_rdata[95:64];
                    n_fprice = e_rdata[63:0];
                end else if (!v_rdata[r_way] && !r_free) begin
                    n_free     = 1'b1;
                    n_free_way = r_way;
                end
                if (!cmp_hit && !last_way) n_way = r_way + 1'b1;
            end
            ofe_pkg::S_EXEC: begin
                n_strobe   = 1'b1;
                n_o_status = ofe_pkg::ST_OK;
                n_o_full   = 1'b0;
                case (r_kind)
                    ofe_pkg::KIND_ADD: begin
                        if (r_found || r_free) begin
                            e_wway           = r_found ? r_fway : r_free_way;
                            e_we             = 1'b1;
                            v_we             = 1'b1;
                            v_wdata[e_wway]  = 1'b1;
                        end else begin
                            n_o_status = ofe_pkg::ST_FULL;
                        end
                    end
                    ofe_pkg::KIND_DEL: begin
                        if (r_found) begin
                            n_o_qty           = r_fsize;
                            n_o_price         = r_fprice;
                            v_we              = 1'b1;
                            v_wdata[r_fway]   = 1'b0;
                        end else begin
                            n_o_status = ofe_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (!r_found) begin
                            n_o_status = ofe_pkg::ST_NOT_FOUND;
                        end else if (r_fsize <= r_qty) begin
                            n_o_full          = 1'b1;
                            v_we              = 1'b1;
                            v_wdata[r_fway]   = 1'b0;
                        end else begin
                            e_we    = 1'b1;
                            e_wdata = {r_id, r_fsize - r_qty, r_fprice};
                        end
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ofe_pkg::S_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
        end
        r_row      <= n_row;
        r_way      <= n_way;
        r_sidx     <= n_sidx;
        r_found    <= n_found;
        r_fway     <= n_fway;
        r_fsize    <= n_fsize;
        r_fprice   <= n_fprice;
        r_free     <= n_free;
        r_free_way <= n_free_way;
        r_vrow     <= n_vrow;
        r_kind     <= n_kind;
        r_id       <= n_id;
        r_qty      <= n_qty;
        r_price    <= n_price;
        r_o_kind   <= n_o_kind;
        r_o_seq    <= n_o_seq;
        r_o_ts     <= n_o_ts;
        r_o_id     <= n_o_id;
        r_o_side   <= n_o_side;
        r_o_qty    <= n_o_qty;
        r_o_price  <= n_o_price;
        r_o_full   <= n_o_full;
        r_o_status <= n_o_status;
    end

    assign o_strobe         = r_strobe;
    assign o_out_kind       = r_o_kind;
    assign o_out_seq_num    = r_o_seq;
    assign o_out_timestamp  = r_o_ts;
    assign o_out_ord_key    = r_o_id;
    assign o_out_side       = r_o_side;
    assign o_out_quantity   = r_o_qty;
    assign o_out_price_bits = r_o_price;
    assign o_full_exec      = r_o_full;
    assign o_status         = r_o_status;
endmodule
`default_nettype wire

FILE: sim/order_feed_enricher_core_tb.sv
// Self-checking testbench for the order feed enricher core: directed and random events.
`default_nettype none
module order_feed_enricher_core_tb;

    localparam int SETS       = ofe_pkg::ORDERS_PER_SIDE / ofe_pkg::TABLE_WAYS;
    localparam int ENTRIES    = ofe_pkg::SIDE_COUNT * ofe_pkg::ORDERS_PER_SIDE;
    localparam int MAX_CYCLES = 900000;
    localparam logic [7:0] SIDE0    = ofe_pkg::SIDE_BASE;
    localparam logic [7:0] SIDE1    = ofe_pkg::SIDE_BASE + 8'd1;
    localparam logic [8:0] SIDE_END = 9'(ofe_pkg::SIDE_BASE) + 9'(ofe_pkg::SIDE_COUNT);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq_num;
        logic [63:0] timestamp;
        logic [63:0] ord_key;
        logic [7:0]  side;
        logic [31:0] quantity;
        logic [63:0] price_bits;
        logic        full_exec;
        logic [2:0]  status;
    } t_event_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_kind;
    logic [31:0] i_seq_num;
    logic [63:0] i_timestamp;
    logic [63:0] i_ord_key;
    logic [7:0]  i_side;
    logic [31:0] i_quantity;
    logic [63:0] i_price_bits;
    logic        o_strobe;
    logic [2:0]  o_out_kind;
    logic [31:0] o_out_seq_num;
    logic [63:0] o_out_timestamp;
    logic [63:0] o_out_ord_key;
    logic [7:0]  o_out_side;
    logic [31:0] o_out_quantity;
    logic [63:0] o_out_price_bits;
    logic        o_full_exec;
    logic [2:0]  o_status;

    order_feed_enricher_core u_dut (.*);

    // Shadow order table
    logic        book_valid [ENTRIES];
    logic [63:0] book_key   [ENTRIES];
    logic [31:0] book_size  [ENTRIES];
    logic [63:0] book_price [ENTRIES];

    t_event_res  expected_beats[$];
    logic [63:0] live_ids[$];
    int          cycle_count;
    int          mismatches;
    int          beats_sent;
    int          beats_checked;
    int          cnt_full;
    int          cnt_not_found;
    bit          idle_on;
    logic [31:0] seq_ctr;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int set_base_of(input int side_idx, input logic [63:0] id);
        logic [31:0] h;
        h = id[31:0] ^ id[63:32];
        h = h ^ (h >> 16);
        return side_idx * ofe_pkg::ORDERS_PER_SIDE + int'(h % SETS) * ofe_pkg::TABLE_WAYS;
    endfunction

    function automatic t_event_res enrich_event(input logic [2:0] kind, input logic [31:0] seq,
                                                input logic [63:0] ts, input logic [63:0] id,
                                                input logic [7:0] side, input logic [31:0] qty,
                                                input logic [63:0] price);
        t_event_res r;
        bit side_ok;
        int base;
        int slot;
        r = '{kind, seq, ts, id, side, qty, price, 1'b0, ofe_pkg::ST_OK};
        side_ok = side >= ofe_pkg::SIDE_BASE && {1'b0, side} < SIDE_END;
        base = side_ok ? set_base_of(int'(side - ofe_pkg::SIDE_BASE), id) : 0;
        slot = -1;
        if (side_ok && kind <= ofe_pkg::KIND_EXEC)
            for (int w = 0; w < ofe_pkg::TABLE_WAYS; w++)
                if (slot < 0 && book_valid[base+w] && book_key[base+w] == id) slot = base + w;
        case (kind)
            ofe_pkg::KIND_ADD: begin
                if (!side_ok) begin
                    r.status = ofe_pkg::ST_BAD_SIDE;
                end else begin
                    if (slot < 0)
                        for (int w = 0; w < ofe_pkg::TABLE_WAYS; w++)
                            if (slot < 0 && !book_valid[base+w]) slot = base + w;
                    if (slot < 0) begin
                        r.status = ofe_pkg::ST_FULL;
                        cnt_full++;
                    end else begin
                        book_valid[slot] = 1'b1;
                        book_key[slot]   = id;
                        book_size[slot]  = qty;
                        book_price[slot] = price;
                    end
                end
            end
            ofe_pkg::KIND_DEL: begin
                r.quantity   = '0;
                r.price_bits = '0;
                if (!side_ok) r.status = ofe_pkg::ST_BAD_SIDE;
                else if (slot < 0) begin
                    r.status = ofe_pkg::ST_NOT_FOUND;
                    cnt_not_found++;
                end else begin
                    r.quantity   = book_size[slot];
                    r.price_bits = book_price[slot];
                    book_valid[slot] = 1'b0;
                end
            end
            ofe_pkg::KIND_EXEC: begin
                if (!side_ok) r.status = ofe_pkg::ST_BAD_SIDE;
                else if (slot < 0) begin
                    r.status = ofe_pkg::ST_NOT_FOUND;
                    cnt_not_found++;
                end else if (book_size[slot] <= qty) begin
                    r.full_exec = 1'b1;
                    book_valid[slot] = 1'b0;
                end else begin
                    book_size[slot] = book_size[slot] - qty;
                end
            end
            ofe_pkg::KIND_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) book_valid[i] = 1'b0;
                r.ord_key = '0; r.side = '0; r.quantity = '0; r.price_bits = '0;
            end
            default: r.status = ofe_pkg::ST_UNKNOWN;
        endcase
        return r;
    endfunction

    // start stays high after a beat unless an idle gap follows
    task automatic send_event(input logic [2:0] kind, input logic [63:0] id,
                              input logic [7:0] side, input logic [31:0] qty,
                              input logic [63:0] price);
        logic [63:0] ts;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        ts = {$urandom, $urandom};
        seq_ctr = seq_ctr + $urandom_range(1, 3);
        start        <= 1'b1;
        i_kind       <= kind;
        i_seq_num    <= seq_ctr;
        i_timestamp  <= ts;
        i_ord_key    <= id;
        i_side       <= side;
        i_quantity   <= qty;
        i_price_bits <= price;
        do @(posedge i_clk); while (busy);
        expected_beats.push_back(enrich_event(kind, seq_ctr, ts, id, side, qty, price));
        beats_sent++;
        if (kind == ofe_pkg::KIND_ADD && side >= ofe_pkg::SIDE_BASE && {1'b0, side} < SIDE_END)
            live_ids.push_back(id);
        if (kind == ofe_pkg::KIND_CLEAR) live_ids.delete();
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_event_res got;
        t_event_res exp_r;
        if (i_rst_n && o_strobe) begin
            got = '{o_out_kind, o_out_seq_num, o_out_timestamp, o_out_ord_key, o_out_side,
                    o_out_quantity, o_out_price_bits, o_full_exec, o_status};
            beats_checked++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %p", got);
            end else begin
                exp_r = expected_beats.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch seq %0d\n  exp %p\n  got %p",
                                 exp_r.seq_num, exp_r, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("order_feed_enricher_core_tb failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_side();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9) return SIDE0;
        if (r < 18) return SIDE1;
        return 8'($urandom);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Ids that all land in set zero of each side: lo ^ hi folded gives a multiple of SETS
    function automatic logic [63:0] colliding_id(input int n);
        logic [31:0] lo;
        lo = 32'(n * SETS);
        return {32'h0, lo};
    endfunction

    task automatic test_extremes();
        send_event(ofe_pkg::KIND_ADD, '1, SIDE0, '1, '1);
        send_event(ofe_pkg::KIND_ADD, '0, SIDE1, '0, '0);
        send_event(ofe_pkg::KIND_EXEC, '0, SIDE1, '0, rand64());
        send_event(ofe_pkg::KIND_EXEC, '1, SIDE0, 32'h1, rand64());
        send_event(ofe_pkg::KIND_EXEC, '1, SIDE0, 32'h1, rand64());
        send_event(ofe_pkg::KIND_DEL, '1, SIDE0, $urandom, rand64());
        send_event(ofe_pkg::KIND_DEL, '1, SIDE0, '0, '0);
        send_event(ofe_pkg::KIND_EXEC, 64'h55, SIDE1, '1, '1);
        send_event(ofe_pkg::KIND_ADD, 64'h7, 8'hff, '1, '1);
        send_event(ofe_pkg::KIND_DEL, 64'h7, 8'h2f, '1, '1);
        send_event(ofe_pkg::KIND_EXEC, 64'h7, 8'h32, '1, '1);
        for (int k = 4; k < 8; k++) send_event(3'(k), rand64(), 8'($urandom), $urandom, rand64());
    endtask

    task automatic test_set_overflow();
        for (int n = 1; n <= ofe_pkg::TABLE_WAYS + 1; n++)
            send_event(ofe_pkg::KIND_ADD, colliding_id(n), SIDE0, $urandom, rand64());
        send_event(ofe_pkg::KIND_ADD, colliding_id(1), SIDE0, 32'd500, rand64());
        send_event(ofe_pkg::KIND_EXEC, colliding_id(1), SIDE0, 32'd200, rand64());
        send_event(ofe_pkg::KIND_DEL, colliding_id(1), SIDE0, '0, '0);
        send_event(ofe_pkg::KIND_CLEAR, rand64(), 8'($urandom), $urandom, rand64());
        send_event(ofe_pkg::KIND_DEL, colliding_id(2), SIDE0, '0, '0);
    endtask

    task automatic test_random_feed(input int count);
        int r;
        logic [63:0] id;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
                id = live_ids[$urandom_range(0, live_ids.size() - 1)];
            else if ($urandom_range(0, 4) == 0)
                id = colliding_id($urandom_range(1, 12));
            else
                id = rand64();
            if (r < 40)
                send_event(ofe_pkg::KIND_ADD, id, pick_side(),
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1000),
                           rand64());
            else if (r < 65)
                send_event(ofe_pkg::KIND_EXEC, id, pick_side(),
                           $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600),
                           rand64());
            else if (r < 92)
                send_event(ofe_pkg::KIND_DEL, id, pick_side(), $urandom, rand64());
            else if (r < 94)
                send_event(ofe_pkg::KIND_CLEAR, id, 8'($urandom), $urandom, rand64());
            else
                send_event(3'($urandom_range(4, 7)), id, 8'($urandom), $urandom, rand64());
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            book_valid[i] = 1'b0;
            book_key[i]   = '0;
            book_size[i]  = '0;
            book_price[i] = '0;
        end
        i_rst_n = 1'b0; start = 1'b0; i_kind = '0; i_seq_num = '0; i_timestamp = '0;
        i_ord_key = '0; i_side = '0; i_quantity = '0; i_price_bits = '0;
        cycle_count = 0; mismatches = 0; beats_sent = 0; beats_checked = 0;
        cnt_full = 0; cnt_not_found = 0; idle_on = 1'b1; seq_ctr = $urandom;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_set_overflow();
        test_random_feed(550);
        idle_on = 1'b0;
        test_random_feed(120);
        start <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("sent %0d events, checked %0d result beats", beats_sent, beats_checked);
        $display("table full %0d times, order not found %0d times", cnt_full, cnt_not_found);
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("order_feed_enricher_core_tb passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("order_feed_enricher_core_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
